FILE: design/rtt_pkg.sv
// Package for the repeating timer table: sizes, op and result codes, shared types.
// Depends on nothing; every other file imports it.
package rtt_pkg;
  localparam int NUM_TIMERS = 32;
  localparam int TIME_BITS  = 48;
  localparam int SLOT_BITS  = 5;
  localparam int IDX_BITS   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_PAUSE   = 3'd2;
  localparam logic [2:0] OP_RESUME  = 3'd3;
  localparam logic [2:0] OP_STOP    = 3'd4;
  localparam logic [2:0] OP_STOPALL = 3'd5;

  localparam logic [2:0] K_DONE    = 3'd0;
  localparam logic [2:0] K_FIRED   = 3'd1;
  localparam logic [2:0] K_STARTED = 3'd2;
  localparam logic [2:0] K_FAILED  = 3'd3;
  localparam logic [2:0] K_IGNORED = 3'd4;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] delta_ticks;
    logic [31:0] interval_ticks;
    logic [31:0] repeat_count;
    logic [4:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  timer_slot;
    logic [31:0] timer_id;
    logic [31:0] remaining;
    logic        last;
  } out_item_t;

  // Saturating time add, one wide add and compare.
  function automatic time_t sat_add(time_t a, time_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction
endpackage

FILE: design/rtt_if.sv
// Valid/ready channel interfaces for the timer table's input and result items.
// Depends on rtt_pkg.
interface rtt_in_if (input logic clk);
  import rtt_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rtt_out_if (input logic clk);
  import rtt_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/rtt_slot_ram.sv
// Per-slot timer storage: one memory row per slot, one read and one write port.
// Depends on rtt_pkg.
module rtt_slot_ram (
  input  logic                   clk,
  input  logic                   we,
  input  logic [rtt_pkg::IDX_BITS-1:0] waddr,
  input  logic [2*rtt_pkg::TIME_BITS+31:0] wdata,
  input  logic [rtt_pkg::IDX_BITS-1:0] raddr,
  output logic [2*rtt_pkg::TIME_BITS+31:0] rdata
);
  import rtt_pkg::*;
  // Row holds due_time, paused_at and period; never-written rows are undefined.
  logic [2*TIME_BITS+31:0] mem [NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: design/repeating_timer_table_top.sv
// Top level of the repeating timer table: sequencer, per-slot control flops, output register.
// Depends on rtt_pkg, rtt_if and rtt_slot_ram.
//
// A table of NUM_TIMERS repeating timers on integer ticks. Each input item is one op
// (tick, start, pause, resume, stop, stop all); results leave on the out channel, the
// final result of an op marked with last. A tick walks the slots in order through one
// shared saturating adder and compare, reading each slot's due time, period and pause
// time from a memory with one read and one write port: each slot passes through the
// address, evaluate and advance states, and the walk stalls in evaluate while a fire
// result waits for the sink; the done result follows the last slot. Start searches the
// free bit vector directly and offers its result the cycle after the item is taken;
// pause, resume and stop read their slot row once and offer the result loaded in the
// evaluate state; stop all walks the slots one per cycle and offers its result after
// the last slot. The block accepts one item at a time; in_ready is high only when it
// is idle and the result register is empty.
// No clearing pass is needed after reset: a row is acted on only for an active slot,
// and start writes the row when the slot becomes active.
module repeating_timer_table_top (
  input logic      clk,
  input logic      rst_n,
  rtt_in_if.sink   in_ch,
  rtt_out_if.source out_ch
);
  import rtt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1; // row address presented
  localparam logic [2:0] S_EVAL = 3'd2; // row data valid, compute
  localparam logic [2:0] S_EMIT = 3'd3; // never entered; S_EVAL and S_DONE wait for the result to drain
  localparam logic [2:0] S_NEXT = 3'd4; // advance slot index
  localparam logic [2:0] S_DONE = 3'd5; // final result

  logic [2:0]  state_r, state_nxt;
  in_item_t    item_r;
  time_t       now_r;
  logic [31:0] idc_r;
  logic [31:0] fires_r [NUM_TIMERS];
  logic [31:0] sid_r [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] paused_r;
  logic [IDX_BITS-1:0] idx_r;
  logic        ov_r;
  out_item_t   ov_d;

  logic        we;
  logic [IDX_BITS-1:0] waddr, raddr;
  logic [2*TIME_BITS+31:0] wdata, rdata;
  time_t       due, pat, add_a, add_b, sum;
  logic [31:0] per;

  rtt_slot_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  assign due = rdata[2*TIME_BITS+31 -: TIME_BITS];
  assign pat = rdata[TIME_BITS+31 -: TIME_BITS];
  assign per = rdata[31:0];
  assign sum = sat_add(add_a, add_b);

  logic [NUM_TIMERS-1:0] act;
  logic [IDX_BITS-1:0]   free_idx;
  logic                  free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      act[i] = fires_r[i] != 32'd0;
      if (fires_r[i] == 32'd0) begin
        free_idx = IDX_BITS'(i);
        free_any = 1'b1;
      end
    end
  end

  // The slot under the tick walk is active, running and due.
  logic fire;
  assign fire = act[idx_r] && !paused_r[idx_r] && now_r >= due;

  logic slot_ok;
  assign slot_ok = {1'b0, item_r.slot} < (SLOT_BITS+1)'(NUM_TIMERS);
  logic [IDX_BITS-1:0] sidx;
  assign sidx = item_r.slot[IDX_BITS-1:0];

  assign in_ch.ready  = (state_r == S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = ov_d;
  assign raddr = (item_r.op == OP_TICK) ? idx_r : sidx;

  logic out_free;
  assign out_free = !ov_r || out_ch.ready;

  // Load the result register: start and unknown ops at accept, a fire or a slot op
  // result at evaluate, the closing done result of tick and stop all.
  logic ov_set;
  assign ov_set = (state_r == S_IDLE && in_ch.valid && in_ch.ready &&
                   !(in_ch.data.op inside {OP_TICK, OP_PAUSE, OP_RESUME, OP_STOP,
                                           OP_STOPALL})) ||
                  (state_r == S_EVAL && out_free && (item_r.op != OP_TICK || fire)) ||
                  (state_r == S_DONE && out_free);

  always_comb begin
    add_a = now_r;
    add_b = time_t'(item_r.delta_ticks);
    waddr = idx_r; wdata = rdata;
    state_nxt = state_r;
    case (state_r)
      S_EVAL: begin
        if (item_r.op == OP_TICK) begin
          add_a = due; add_b = time_t'(per);
          wdata = {sum, pat, per};
        end else begin
          add_a = due; add_b = now_r - pat;
          // Pause keeps the due time and records the pause time; resume delays due.
          wdata = (item_r.op == OP_PAUSE) ? {due, now_r, per} : {sum, pat, per};
          waddr = sidx;
        end
      end
      S_IDLE: begin
        add_a = now_r;
        add_b = time_t'((in_ch.data.op == OP_TICK) ? in_ch.data.delta_ticks
                                                    : in_ch.data.interval_ticks);
        wdata = {sum, now_r, in_ch.data.interval_ticks};
        waddr = free_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      now_r    <= '0;
      idc_r    <= '0;
      paused_r <= '0;
      ov_r     <= 1'b0;
      idx_r    <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        fires_r[i] <= '0;
        sid_r[i]   <= '0;
      end
    end else begin
      // Hold the result until the sink takes it, unless a new one loads.
      ov_r <= ov_set || (ov_r && !out_ch.ready);
      case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          item_r <= in_ch.data;
          idx_r  <= '0;
          case (in_ch.data.op)
            OP_TICK: begin
              now_r   <= sum;
              state_r <= S_RD;
            end
            OP_START: begin
              if (in_ch.data.repeat_count != 32'd0 && free_any) begin
                // Write the new row through the write port in this cycle.
                fires_r[free_idx]  <= in_ch.data.repeat_count;
                paused_r[free_idx] <= 1'b0;
                sid_r[free_idx]    <= idc_r + 32'd1;
                idc_r <= idc_r + 32'd1;
                ov_d  <= '{K_STARTED, SLOT_BITS'(free_idx), idc_r + 32'd1,
                           in_ch.data.repeat_count, 1'b1};
              end else begin
                ov_d <= '{K_FAILED, 5'd0, 32'd0, 32'd0, 1'b1};
              end
            end
            OP_PAUSE, OP_RESUME, OP_STOP: state_r <= S_RD;
            OP_STOPALL: state_r <= S_NEXT;
            default: begin
              ov_d <= '{K_IGNORED, 5'd0, 32'd0, 32'd0, 1'b1};
            end
          endcase
        end
        S_RD: state_r <= S_EVAL;
        S_EVAL: begin
          if (item_r.op == OP_TICK) begin
            if (fire) begin
              if (out_free) begin
                ov_d <= '{K_FIRED, SLOT_BITS'(idx_r), sid_r[idx_r],
                          fires_r[idx_r] - 32'd1, 1'b0};
                fires_r[idx_r] <= fires_r[idx_r] - 32'd1;
                if (fires_r[idx_r] == 32'd1) begin
                  paused_r[idx_r] <= 1'b0;
                  sid_r[idx_r]    <= idc_r + 32'd1;
                  idc_r <= idc_r + 32'd1;
                end
                state_r <= S_NEXT;
              end
            end else begin
              state_r <= S_NEXT;
            end
          end else if (out_free) begin
            state_r <= S_IDLE;
            if (!slot_ok) begin
              ov_d <= '{K_IGNORED, item_r.slot, 32'd0, 32'd0, 1'b1};
            end else if (act[sidx] && item_r.op == OP_PAUSE && !paused_r[sidx]) begin
              paused_r[sidx] <= 1'b1;
              ov_d <= '{K_DONE, item_r.slot, sid_r[sidx], fires_r[sidx], 1'b1};
            end else if (act[sidx] && item_r.op == OP_RESUME && paused_r[sidx]) begin
              paused_r[sidx] <= 1'b0;
              ov_d <= '{K_DONE, item_r.slot, sid_r[sidx], fires_r[sidx], 1'b1};
            end else if (act[sidx] && item_r.op == OP_STOP) begin
              fires_r[sidx]  <= '0;
              paused_r[sidx] <= 1'b0;
              sid_r[sidx]    <= idc_r + 32'd1;
              idc_r <= idc_r + 32'd1;
              ov_d <= '{K_DONE, item_r.slot, idc_r + 32'd1, 32'd0, 1'b1};
            end else begin
              ov_d <= '{K_IGNORED, item_r.slot, sid_r[sidx], fires_r[sidx], 1'b1};
            end
          end
        end
        S_NEXT: begin
          if (item_r.op == OP_STOPALL && act[idx_r]) begin
            fires_r[idx_r]  <= '0;
            paused_r[idx_r] <= 1'b0;
            sid_r[idx_r]    <= idc_r + 32'd1;
            idc_r <= idc_r + 32'd1;
          end
          if (idx_r == IDX_BITS'(NUM_TIMERS - 1)) begin
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= (item_r.op == OP_TICK) ? S_RD : S_NEXT;
          end
        end
        S_DONE: if (out_free) begin
          ov_d <= '{K_DONE, 5'd0, 32'd0, 32'd0, 1'b1};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Row writes: start (idle), tick fire, pause, resume.
  logic start_go;
  assign start_go = state_r == S_IDLE && in_ch.valid && in_ch.ready &&
                    in_ch.data.op == OP_START && in_ch.data.repeat_count != 32'd0 &&
                    free_any;
  assign we = start_go ||
              (state_r == S_EVAL && item_r.op == OP_TICK && out_free && fire) ||
              (state_r == S_EVAL && out_free && slot_ok && act[sidx] &&
               ((item_r.op == OP_RESUME && paused_r[sidx]) ||
                (item_r.op == OP_PAUSE && !paused_r[sidx])));

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.last |-> state_r == S_IDLE)
    else $error("last while busy");
endmodule
